// ===== rtl/stopped_duration_tracker_macros.svh =====
// Assertion macros shared by the checker of the stopped duration tracker.
// Holds only macro definitions; no dependencies.
`ifndef STOPPED_DURATION_TRACKER_MACROS_SVH
`define STOPPED_DURATION_TRACKER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SDT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SDT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== rtl/sdt_pkg.sv =====
// Package of the stopped duration tracker: widths, codes and shared types.
// No dependencies.
package sdt_pkg;
    localparam int ENTRIES_DEF = 64;
    localparam int TW = 63;
    localparam int IDW = 64;
    localparam int VW = 20;
    localparam int THRW = 19;
    localparam int TOW = 40;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_OBJ   = 2'd1;
    localparam logic [1:0] CMD_EGO   = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_IGN    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NODUR  = 2'd3;

    localparam logic CFG_THR = 1'b0;
    localparam logic CFG_TO  = 1'b1;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]     cmd;
        logic [TW-1:0]  stamp;
        logic [IDW-1:0] id_hi;
        logic [IDW-1:0] id_lo;
        logic           stopped;
    } t_item;
endpackage

// ===== rtl/stopped_duration_tracker.sv =====
// Top level of the stopped duration tracker: config registers, front, queue, back.
// Depends on sdt_pkg, sdt_front, sdt_queue and sdt_back.
//
//  channel  | handshake            | fields
//  input    | i_valid / o_ready    | command, stamp, uuid_high, uuid_low, vel_x, vel_y
//  output   | o_valid / i_ready    | status, duration_ns
//  config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// Frame starts, object items and queries scan the table: each entry is read in S_RD
// and checked in S_CHK, then the hit entry is fetched. Ego items skip the scan;
// ignored frames and objects go straight to output. The table has a single read port.
// Reset is synchronous; the valid bits of the table clear at once, no sweep.
// The front stages keep accepting while the back is busy, until the queue fills.
module stopped_duration_tracker import sdt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_command,
    input  logic [TW-1:0]   i_stamp,
    input  logic [IDW-1:0]  i_uuid_high,
    input  logic [IDW-1:0]  i_uuid_low,
    input  logic signed [VW-1:0] i_vel_x,
    input  logic signed [VW-1:0] i_vel_y,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [TOW-1:0]  i_cfg_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_status,
    output logic [TW-1:0]   o_duration_ns
);
    logic [THRW-1:0] r_thr;
    logic [TOW-1:0]  r_to;
    logic  f_v, q_r, q_v, b_r;
    t_item f_it, q_it;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRW'(100);
            r_to  <= TOW'(1000000000);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_THR) r_thr <= i_cfg_data[THRW-1:0];
            if (i_cfg_index == CFG_TO)  r_to  <= i_cfg_data;
        end
    end

    sdt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_stamp, .i_uuid_high,
        .i_uuid_low, .i_vel_x, .i_vel_y, .i_thr(r_thr),
        .o_valid(f_v), .i_ready(q_r), .o_item(f_it)
    );

    sdt_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(q_r), .i_item(f_it),
        .o_valid(q_v), .i_ready(b_r), .o_item(q_it)
    );

    sdt_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(b_r), .i_item(q_it),
        .i_timeout(r_to), .o_valid, .i_ready, .o_status, .o_duration_ns
    );
endmodule

// ===== rtl/sdt_front.sv =====
// Front part: accepts items and classifies the velocity as stopped or moving.
// Depends on sdt_pkg; two registered stages, with all multipliers in the second.
module sdt_front import sdt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_command,
    input  logic [TW-1:0]   i_stamp,
    input  logic [IDW-1:0]  i_uuid_high,
    input  logic [IDW-1:0]  i_uuid_low,
    input  logic signed [VW-1:0] i_vel_x,
    input  logic signed [VW-1:0] i_vel_y,
    input  logic [THRW-1:0] i_thr,
    output logic            o_valid,
    input  logic            i_ready,
    output t_item           o_item
);
    logic          r_v1;
    t_item         r_it1;
    logic [VW-1:0] r_ax, r_ay;
    logic [THRW-1:0] r_thr;
    logic [VW-1:0] ax, ay;
    logic [2*VW:0] sq;
    logic [2*THRW-1:0] tsq;
    logic          adv;

    assign ax = i_vel_x[VW-1] ? VW'(-i_vel_x) : i_vel_x;
    assign ay = i_vel_y[VW-1] ? VW'(-i_vel_y) : i_vel_y;
    assign adv = !o_valid || i_ready;
    assign o_ready = !r_v1 || adv;

    // Squares in the second stage.
    assign sq  = (2*VW+1)'(r_ax) * (2*VW+1)'(r_ax) + (2*VW+1)'(r_ay) * (2*VW+1)'(r_ay);
    assign tsq = r_thr * r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (adv) o_valid <= r_v1;
        end
        if (o_ready && i_valid) begin
            r_it1 <= '{i_command, i_stamp, i_uuid_high, i_uuid_low, 1'b0};
            r_ax <= ax;
            r_ay <= ay;
            r_thr <= i_thr;
        end
        if (adv && r_v1) begin
            o_item <= '{r_it1.cmd, r_it1.stamp, r_it1.id_hi, r_it1.id_lo,
                        sq < (2*VW+1)'(tsq)};
        end
    end
endmodule

// ===== rtl/sdt_queue.sv =====
// Short queue that decouples the front part from the back part.
// Depends on sdt_pkg for the item type.
module sdt_queue import sdt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_item;
    end
endmodule

// ===== rtl/sdt_back.sv =====
// Back part: sequencer that scans the object table and keeps the ego record.
// Depends on sdt_pkg; table ids and times sit in a memory, valid bits in flops.
module sdt_back import sdt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_item          i_item,
    input  logic [TOW-1:0] i_timeout,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic [TW-1:0]  o_duration_ns
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_FETCH, S_DO, S_OUT} t_state;

    typedef struct packed {
        logic [IDW-1:0] hi;
        logic [IDW-1:0] lo;
        logic [TW-1:0]  since;
        logic [TW-1:0]  seen;
    } t_ent;

    t_ent   r_mem [ENTRIES];
    t_ent   r_rd;
    logic [ENTRIES-1:0] r_vld;
    t_state r_st;
    t_item  r_it;
    logic [AW:0] r_idx;
    logic   r_found, r_free_ok;
    logic [AW-1:0] r_hit, r_free;
    logic   r_okt, r_ego_k, r_ego_sp, r_ign;
    logic [TW-1:0] r_ot, r_et, r_es, r_el;
    logic   r_we;
    logic [AW-1:0] r_wa;
    t_ent   r_wd;
    logic [AW-1:0] idx;
    logic [TW:0]   diff;
    logic          exp_hit, id_hit;
    logic [TW:0]   ediff;
    logic [TW-1:0] de, dob;

    assign idx = r_idx[AW-1:0];
    assign o_ready = r_st == S_IDLE && !o_valid;
    assign diff = {1'b0, r_ot} - {1'b0, r_rd.seen};
    assign exp_hit = r_ot > r_rd.seen && diff > (TW+1)'(i_timeout);
    assign id_hit = r_vld[idx] && r_rd.hi == r_it.id_hi && r_rd.lo == r_it.id_lo;
    assign ediff = {1'b0, r_it.stamp} - {1'b0, r_el};
    assign de = r_et >= r_es ? r_et - r_es : '0;
    assign dob = r_ot >= r_rd.since ? r_ot - r_rd.since : '0;

    // Table memory with a registered read port; the hit entry is fetched after the scan.
    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_wa] <= r_wd;
        r_rd <= r_mem[r_st == S_FETCH ? r_hit : idx];
    end

    // Table write of a refreshed or new entry, in the cycle after the decision.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_we <= 1'b0;
        else r_we <= r_st == S_DO && r_it.cmd == CMD_OBJ && r_it.stopped &&
                     (r_found || r_free_ok);
        r_wa <= r_found ? r_hit : r_free;
        r_wd <= r_found ? {r_rd.hi, r_rd.lo, r_rd.since, r_ot}
                        : {r_it.id_hi, r_it.id_lo, r_ot, r_ot};
    end

    // Sequencer: during a scan each entry is read in S_RD and checked in S_CHK.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_valid <= 1'b0;
            r_vld <= '0;
            r_okt <= 1'b0; r_ot <= '0; r_ign <= 1'b0;
            r_ego_k <= 1'b0; r_et <= '0; r_ego_sp <= 1'b0;
            r_es <= '0; r_el <= '0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    r_it <= i_item;
                    r_idx <= '0;
                    r_found <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_hit <= '0;
                    r_free <= '0;
                    o_duration_ns <= '0;
                    case (i_item.cmd)
                        CMD_FRAME: begin
                            if (r_okt && i_item.stamp == r_ot) begin
                                r_ign <= 1'b1;
                                o_status <= ST_IGN;
                                r_st <= S_OUT;
                            end else begin
                                if (r_okt && i_item.stamp < r_ot) r_vld <= '0;
                                r_okt <= 1'b1;
                                r_ot <= i_item.stamp;
                                r_ign <= 1'b0;
                                o_status <= ST_DONE;
                                r_st <= S_RD;
                            end
                        end
                        CMD_OBJ: begin
                            if (!r_okt || r_ign) begin
                                o_status <= ST_IGN;
                                r_st <= S_OUT;
                            end else begin
                                o_status <= ST_DONE;
                                r_st <= S_RD;
                            end
                        end
                        CMD_EGO: begin
                            o_status <= ST_DONE;
                            r_st <= S_DO;
                        end
                        default: begin
                            o_status <= ST_DONE;
                            r_st <= S_RD;
                        end
                    endcase
                end
                S_RD: r_st <= S_CHK;
                S_CHK: begin
                    if (r_it.cmd == CMD_FRAME) begin
                        if (r_vld[idx] && exp_hit) r_vld[idx] <= 1'b0;
                    end else begin
                        if (id_hit && !r_found) begin
                            r_found <= 1'b1;
                            r_hit <= idx;
                        end
                        if (!r_vld[idx] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free <= idx;
                        end
                    end
                    if (r_idx == (AW+1)'(ENTRIES - 1)) r_st <= S_FETCH;
                    else begin
                        r_idx <= r_idx + 1'b1;
                        r_st <= S_RD;
                    end
                end
                S_FETCH: r_st <= S_DO;
                S_DO: begin
                    r_st <= S_OUT;
                    case (r_it.cmd)
                        CMD_OBJ: begin
                            if (!r_it.stopped) begin
                                if (r_found) r_vld[r_hit] <= 1'b0;
                            end else if (!r_found) begin
                                if (r_free_ok) r_vld[r_free] <= 1'b1;
                                else o_status <= ST_FULL;
                            end
                        end
                        CMD_EGO: begin
                            if (r_ego_k && r_it.stamp == r_et) o_status <= ST_IGN;
                            else begin
                                r_ego_k <= 1'b1;
                                r_et <= r_it.stamp;
                                if (!r_it.stopped) r_ego_sp <= 1'b0;
                                else if (!r_ego_sp || (r_ego_k && r_it.stamp < r_et) ||
                                         (r_it.stamp > r_el && ediff > (TW+1)'(i_timeout)))
                                begin
                                    r_ego_sp <= 1'b1;
                                    r_es <= r_it.stamp;
                                    r_el <= r_it.stamp;
                                end else r_el <= r_it.stamp;
                            end
                        end
                        CMD_QUERY: begin
                            // The hit entry was fetched in the previous cycle.
                            if (!r_ego_sp || !r_ego_k || !r_found || !r_okt)
                                o_status <= ST_NODUR;
                            else
                                o_duration_ns <= de < dob ? de : dob;
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/sdt_checker.sv =====
// Port-level checker of the stopped duration tracker and its bind.
// Depends on sdt_pkg and stopped_duration_tracker_macros.svh.
`include "stopped_duration_tracker_macros.svh"
module sdt_checker import sdt_pkg::*; (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input logic [1:0]     o_status,
    input logic [TW-1:0]  o_duration_ns
);
    `SDT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `SDT_ASSERT_IMPL(a_dur_done, i_clk, i_rst_n, o_valid && o_status != ST_DONE, o_duration_ns == '0)
    `SDT_ASSERT_NEXT(a_gap, i_clk, i_rst_n, o_valid && i_ready, !o_valid)
endmodule

bind stopped_duration_tracker sdt_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_status, .o_duration_ns
);
